>>> rtl/core/radix_digit_converter_macros.svh
// assertion macros used by the checker of the digit converter
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rdc_pkg.sv
package rdc_pkg;

  localparam int VALUE_W        = 63;
  localparam int VALUE_BITS_DEF = 63;
  localparam int RADIX_W        = 5;
  localparam int REM_W          = 4;
  localparam int CHAR_W         = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_F    = 7'd70;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take a new value, clear the partial remainder
    logic step;   // one shift-subtract step of the division
    logic emit;   // move the finished digit into the output register
  } rdc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic q_zero;    // quotient is zero: the current digit is the last
    logic out_free;  // output register can take a digit this cycle
  } rdc_status_t;

  function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < BASE_MIN) b = BASE_MIN;
    if (r > BASE_MAX) b = BASE_MAX;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) c = CHAR_ZERO + CHAR_W'(d);
    else           c = CHAR_A + CHAR_W'(d) - 7'd10;
    return c;
  endfunction

endpackage

>>> rtl/core/rdc_ctrl.sv
module rdc_ctrl
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rdc_status_t status,
  output rdc_cmd_t    cmd
);

  localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = status.q_zero ? ST_IDLE : ST_DIV;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/rdc_datapath.sv
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               cfg_valid,
  input  logic [RADIX_W-1:0] cfg_radix,
  input  rdc_cmd_t           cmd,
  output rdc_status_t        status,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last,
  output logic               out_empty_res
);

  logic [RADIX_W-1:0]    radix_r;
  logic [VALUE_BITS-1:0] q_r;
  logic [REM_W-1:0]      rem_r;
  logic                  zero_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     digit_r;
  logic                  last_r;
  logic                  empty_r;

  logic [RADIX_W-1:0] base;
  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               ge;
  logic [REM_W-1:0]   rem_nxt;

  // restoring shift-subtract, one quotient bit a cycle
  assign base    = eff_base(radix_r);
  assign trial   = {rem_r, q_r[VALUE_BITS-1]};
  assign ge      = (trial >= base);
  assign diff    = trial - base;
  assign rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

  assign status.q_zero   = (q_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) radix_r <= cfg_radix;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r    <= in_value[VALUE_BITS-1:0];
      rem_r  <= '0;
      zero_r <= (in_value[VALUE_BITS-1:0] == '0);
    end else if (cmd.step) begin
      q_r   <= {q_r[VALUE_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end else if (cmd.emit) begin
      rem_r <= '0;
    end
    if (cmd.emit) begin
      digit_r <= ascii_of(rem_r);
      last_r  <= status.q_zero;
      empty_r <= zero_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = digit_r;
  assign out_last       = last_r;
  assign out_empty_res  = empty_r;

endmodule

>>> rtl/core/radix_digit_converter.sv
// radix_digit_converter: writes a non-negative integer out as digits of a base
// from 2 to 16, one ascii character '0'-'9' / 'A'-'F' per result item
// input channel: in_valid / in_stall with in_value; an item is taken while idle
// result channel: out_valid / out_stall; digits come least significant first,
//   out_last marks the most significant digit, a zero value gives a single '0'
//   item with both out_last and out_empty_res set
// config: cfg_valid / cfg_ready with cfg_radix, always ready, write only while idle;
//   radix 0 and 1 act as base 2, 17 to 31 as base 16
// digits: each digit is one restoring division on the shift-subtract unit,
//   followed by a load of the output register
// a digit waiting in the output register does not block the divider on the
//   next digit; the unit only holds when a second digit is ready and the
//   receiver still stalls, and a new item is taken as soon as the last digit
//   has moved into the output register
// reset (synchronous, rst_n low): controller idle, output empty, radix back to 10
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  // digit output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last,
  output logic               out_empty_res,
  // radix register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_radix
);

  rdc_cmd_t    cmd;
  rdc_status_t status;

  // radix register can always take a write
  assign cfg_ready = 1'b1;

  // sequencer: idle, divide, hand the digit over
  rdc_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // quotient/remainder registers, radix register and output register
  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_radix      (cfg_radix),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res)
  );

endmodule

>>> rtl/core/rdc_checker.sv
`include "radix_digit_converter_macros.svh"

module rdc_checker
  import rdc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CHAR_W-1:0]  out_digit_char,
  input logic               out_last,
  input logic               out_empty_res
);

  // a taken item keeps the input closed for the next cycle
  `RDC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "input open right after an item was taken")

  // a stalled digit holds
  `RDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_digit_char) && $stable(out_last) && $stable(out_empty_res), "stalled digit changed")

  // empty result is a lone '0' that also closes the run
  `RDC_ASSERT_SAME(a_empty_shape, clk, rst_n, out_valid && out_empty_res, out_last && (out_digit_char == CHAR_ZERO), "empty result malformed")

  // only digit characters leave the block
  `RDC_ASSERT_SAME(a_char_range, clk, rst_n, out_valid, ((out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_NINE)) || ((out_digit_char >= CHAR_A) && (out_digit_char <= CHAR_F)), "digit character out of range")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
